@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ src/fpe_pkg.sv @@
// ----------------------------------------------------------------------------
// fpe_pkg
// shared types and constants of the expansion accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package fpe_pkg;

    typedef logic [63:0] double_t;

    localparam int INDEX_W = 4;

    localparam logic [1:0] FUNC_ACC    = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam double_t DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam double_t QUIET_BIT   = 64'h0008_0000_0000_0000;

endpackage

`default_nettype wire

@@ src/fpe_ram.sv @@
// ----------------------------------------------------------------------------
// fpe_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/fpe_fadd.sv @@
// ----------------------------------------------------------------------------
// fpe_fadd
// four stage binary64 adder and subtracter, round to nearest even
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_fadd (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            sub,
    input  wire fpe_pkg::double_t a,
    input  wire fpe_pkg::double_t b,
    output      logic            done,
    output      fpe_pkg::double_t y
);

    // stage 1: unpack, specials, swap, align
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_ge;
    logic [10:0] exa, exb, exx, exy, dexp;
    logic [52:0] ma, mb, mx, my;
    logic [55:0] my_ext, my_sh;
    logic        sx, sy, stk, spec;
    fpe_pkg::double_t spec_y;

    always_comb
    begin
        sa     = a[63];
        sb     = b[63] ^ sub;
        a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
        b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
        a_zero = (a[62:0] == 63'd0);
        b_zero = (b[62:0] == 63'd0);
        exa    = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
        exb    = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
        ma     = {(a[62:52] != 11'd0), a[51:0]};
        mb     = {(b[62:52] != 11'd0), b[51:0]};
        a_ge   = (a[62:0] >= b[62:0]);
        sx     = a_ge ? sa : sb;
        sy     = a_ge ? sb : sa;
        exx    = a_ge ? exa : exb;
        exy    = a_ge ? exb : exa;
        mx     = a_ge ? ma : mb;
        my     = a_ge ? mb : ma;
        dexp   = exx - exy;
        my_ext = {my, 3'b000};
        if (dexp >= 11'd56)
        begin
            my_sh = 56'd0;
            stk   = |my_ext;
        end
        else
        begin
            my_sh = my_ext >> dexp[5:0];
            stk   = |(my_ext & ~({56{1'b1}} << dexp[5:0]));
        end
        spec   = 1'b1;
        spec_y = 64'd0;
        if (a_nan)
        begin
            spec_y = a | fpe_pkg::QUIET_BIT;
        end
        else if (b_nan)
        begin
            spec_y = b | fpe_pkg::QUIET_BIT;
        end
        else if (a_inf && b_inf && (sa != sb))
        begin
            spec_y = fpe_pkg::DEFAULT_NAN;
        end
        else if (a_inf)
        begin
            spec_y = a;
        end
        else if (b_inf)
        begin
            spec_y = {sb, b[62:0]};
        end
        else if (a_zero && b_zero)
        begin
            spec_y = {(sa & sb), 63'd0};
        end
        else
        begin
            spec = 1'b0;
        end
    end

    logic             v1_reg, s1_sign_reg, s1_sub_reg, s1_spec_reg;
    logic [10:0]      s1_exp_reg;
    logic [55:0]      s1_mx_reg, s1_my_reg;
    fpe_pkg::double_t s1_spec_y_reg;

    always_ff @(posedge clk)
    begin
        s1_sign_reg   <= sx;
        s1_sub_reg    <= (sx != sy);
        s1_spec_reg   <= spec;
        s1_spec_y_reg <= spec_y;
        s1_exp_reg    <= exx;
        s1_mx_reg     <= {mx, 3'b000};
        s1_my_reg     <= {my_sh[55:1], my_sh[0] | stk};
    end

    // stage 2: add magnitudes
    logic             v2_reg, s2_sign_reg, s2_spec_reg;
    logic [10:0]      s2_exp_reg;
    logic [56:0]      s2_sum_reg;
    fpe_pkg::double_t s2_spec_y_reg;

    always_ff @(posedge clk)
    begin
        s2_sign_reg   <= s1_sign_reg;
        s2_spec_reg   <= s1_spec_reg;
        s2_spec_y_reg <= s1_spec_y_reg;
        s2_exp_reg    <= s1_exp_reg;
        s2_sum_reg    <= s1_sub_reg ? ({1'b0, s1_mx_reg} - {1'b0, s1_my_reg})
                                    : ({1'b0, s1_mx_reg} + {1'b0, s1_my_reg});
    end

    // stage 3: normalize
    logic [5:0]  lz;
    logic [11:0] exp_m1, nsh;
    logic [55:0] nv;
    logic [11:0] nexp;

    always_comb
    begin
        lz = 6'd56;
        for (int i = 0; i < 56; i++)
        begin
            if (s2_sum_reg[i])
            begin
                lz = 6'(55 - i);
            end
        end
        exp_m1 = {1'b0, s2_exp_reg} - 12'd1;
        nsh    = (exp_m1 < {6'd0, lz}) ? exp_m1 : {6'd0, lz};
        if (s2_sum_reg[56])
        begin
            nv   = {s2_sum_reg[56:2], s2_sum_reg[1] | s2_sum_reg[0]};
            nexp = {1'b0, s2_exp_reg} + 12'd1;
        end
        else
        begin
            nv   = s2_sum_reg[55:0] << nsh[5:0];
            nexp = {1'b0, s2_exp_reg} - nsh;
        end
    end

    logic             v3_reg, s3_sign_reg, s3_spec_reg, s3_zero_reg;
    logic [11:0]      s3_exp_reg;
    logic [55:0]      s3_v_reg;
    fpe_pkg::double_t s3_spec_y_reg;

    always_ff @(posedge clk)
    begin
        s3_sign_reg   <= s2_sign_reg;
        s3_spec_reg   <= s2_spec_reg;
        s3_spec_y_reg <= s2_spec_y_reg;
        s3_zero_reg   <= (s2_sum_reg == 57'd0);
        s3_exp_reg    <= nexp;
        s3_v_reg      <= nv;
    end

    // stage 4: round and pack
    logic             up;
    logic [53:0]      mr;
    logic [52:0]      mf;
    logic [11:0]      ef;
    fpe_pkg::double_t y_next;

    always_comb
    begin
        up = s3_v_reg[2] & (s3_v_reg[1] | s3_v_reg[0] | s3_v_reg[3]);
        mr = {1'b0, s3_v_reg[55:3]} + {53'd0, up};
        if (mr[53])
        begin
            mf = mr[53:1];
            ef = s3_exp_reg + 12'd1;
        end
        else
        begin
            mf = mr[52:0];
            ef = s3_exp_reg;
        end
        if (s3_spec_reg)
        begin
            y_next = s3_spec_y_reg;
        end
        else if (s3_zero_reg)
        begin
            y_next = 64'd0;
        end
        else if (ef >= 12'd2047)
        begin
            y_next = {s3_sign_reg, 11'h7FF, 52'd0};
        end
        else
        begin
            y_next = {s3_sign_reg, (mf[52] ? ef[10:0] : 11'd0), mf[51:0]};
        end
    end

    logic v4_reg;

    always_ff @(posedge clk)
    begin
        y <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign done = v4_reg;

endmodule

`default_nettype wire

@@ src/fp_expansion_accumulator_core.sv @@
// Keeps an expansion of EXPANSION_WORDS binary64 words in a small ram and
// folds each accumulate request through it with an exact TwoSum. A TwoSum
// is six dependent additions through one four stage adder; each word walked
// is read from the ram, summed with the carry and written back. A readout
// steps through every word, and clear and skipped requests stay in idle.
// ----------------------------------------------------------------------------
// fp_expansion_accumulator_core
// floating-point expansion accumulator, twosum walk over ram-held words
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fp_expansion_accumulator_core #(
    parameter int EXPANSION_WORDS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [1:0]       func,
    input  wire logic [63:0]      term,
    input  wire logic             ends_incoming,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic [63:0]      word,
    output      logic [3:0]       word_index,
    output      logic             last_word
);

    localparam int IW   = $clog2(EXPANSION_WORDS);
    localparam int IdxW = fpe_pkg::INDEX_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ACC_RD   = 3'd1;
    localparam logic [2:0] S_ACC_WAIT = 3'd2;
    localparam logic [2:0] S_TS_ISSUE = 3'd3;
    localparam logic [2:0] S_TS_WAIT  = 3'd4;
    localparam logic [2:0] S_ACC_WR   = 3'd5;
    localparam logic [2:0] S_RD_RD    = 3'd6;
    localparam logic [2:0] S_RD_WAIT  = 3'd7;

    // twosum steps
    localparam logic [2:0] OP_R   = 3'd0;
    localparam logic [2:0] OP_Z   = 3'd1;
    localparam logic [2:0] OP_T   = 3'd2;
    localparam logic [2:0] OP_EA  = 3'd3;
    localparam logic [2:0] OP_EB  = 3'd4;
    localparam logic [2:0] OP_ERR = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           op_reg;
    logic [IW-1:0]        idx_reg;
    logic                 skip_reg;
    logic [EXPANSION_WORDS-1:0] vld_reg;
    logic                 rd_vld_reg;
    logic                 out_valid_reg;
    fpe_pkg::double_t     word_reg, carry_reg, r_reg, z_reg, t_reg, ea_reg, eb_reg;
    fpe_pkg::double_t     wout_reg;
    logic [3:0]           widx_reg;
    logic                 wlast_reg;

    logic                 in_acc;
    logic                 is_last;
    logic                 ram_we, ram_re;
    fpe_pkg::double_t     ram_rdata, rd_word;
    logic                 add_start, add_sub, add_done;
    fpe_pkg::double_t     add_a, add_b, add_y;
    logic                 out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign is_last   = (idx_reg == IW'(EXPANSION_WORDS - 1));
    assign ram_we    = (state_reg == S_ACC_WR);
    assign ram_re    = (state_reg == S_ACC_RD) || (state_reg == S_RD_RD);
    assign rd_word   = rd_vld_reg ? ram_rdata : 64'd0;
    assign add_start = (state_reg == S_TS_ISSUE);
    assign out_load  = (state_reg == S_RD_WAIT) && (!out_valid_reg || out_ready);

    fpe_ram #(
        .WIDTH (64),
        .DEPTH (EXPANSION_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (r_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        add_a   = word_reg;
        add_b   = carry_reg;
        add_sub = 1'b0;
        case (op_reg)
            OP_R:
            begin
                add_a = word_reg;
                add_b = carry_reg;
            end
            OP_Z:
            begin
                add_a   = r_reg;
                add_b   = word_reg;
                add_sub = 1'b1;
            end
            OP_T:
            begin
                add_a   = r_reg;
                add_b   = z_reg;
                add_sub = 1'b1;
            end
            OP_EA:
            begin
                add_a   = word_reg;
                add_b   = t_reg;
                add_sub = 1'b1;
            end
            OP_EB:
            begin
                add_a   = carry_reg;
                add_b   = z_reg;
                add_sub = 1'b1;
            end
            OP_ERR:
            begin
                add_a = ea_reg;
                add_b = eb_reg;
            end
            default:
            begin
                add_a = word_reg;
            end
        endcase
    end

    fpe_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .sub   (add_sub),
        .a     (add_a),
        .b     (add_b),
        .done  (add_done),
        .y     (add_y)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (func == fpe_pkg::FUNC_ACC) && !skip_reg
                    && (term[62:0] != 63'd0))
                begin
                    state_next = S_ACC_RD;
                end
                else if (in_acc && (func == fpe_pkg::FUNC_READ))
                begin
                    state_next = S_RD_RD;
                end
            end
            S_ACC_RD:   state_next = S_ACC_WAIT;
            S_ACC_WAIT: state_next = S_TS_ISSUE;
            S_TS_ISSUE: state_next = S_TS_WAIT;
            S_TS_WAIT:
            begin
                if (add_done)
                begin
                    state_next = (op_reg == OP_ERR) ? S_ACC_WR : S_TS_ISSUE;
                end
            end
            S_ACC_WR:
            begin
                state_next = ((carry_reg[62:0] == 63'd0) || is_last) ? S_IDLE : S_ACC_RD;
            end
            S_RD_RD:    state_next = S_RD_WAIT;
            S_RD_WAIT:
            begin
                if (out_load)
                begin
                    state_next = is_last ? S_IDLE : S_RD_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_R;
            idx_reg       <= '0;
            skip_reg      <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                idx_reg <= '0;
                case (func)
                    fpe_pkg::FUNC_ACC:
                    begin
                        if (skip_reg)
                        begin
                            skip_reg <= !ends_incoming;
                        end
                        else if ((term[62:0] == 63'd0) && !ends_incoming)
                        begin
                            skip_reg <= 1'b1;
                        end
                    end
                    fpe_pkg::FUNC_CLEAR:
                    begin
                        skip_reg <= 1'b0;
                        vld_reg  <= '0;
                    end
                    default:
                    begin
                        skip_reg <= skip_reg;
                    end
                endcase
            end
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[idx_reg];
            end
            if (state_reg == S_ACC_WAIT)
            begin
                op_reg <= OP_R;
            end
            else if ((state_reg == S_TS_WAIT) && add_done)
            begin
                op_reg <= op_reg + 3'd1;
            end
            if (ram_we)
            begin
                vld_reg[idx_reg] <= 1'b1;
                if (!is_last)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (!is_last)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            carry_reg <= term;
        end
        if (state_reg == S_ACC_WAIT)
        begin
            word_reg <= rd_word;
        end
        if ((state_reg == S_TS_WAIT) && add_done)
        begin
            case (op_reg)
                OP_R:    r_reg     <= add_y;
                OP_Z:    z_reg     <= add_y;
                OP_T:    t_reg     <= add_y;
                OP_EA:   ea_reg    <= add_y;
                OP_EB:   eb_reg    <= add_y;
                OP_ERR:  carry_reg <= add_y;
                default: r_reg     <= r_reg;
            endcase
        end
        if (out_load)
        begin
            wout_reg  <= rd_word;
            widx_reg  <= IdxW'(idx_reg);
            wlast_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign word       = wout_reg;
    assign word_index = widx_reg;
    assign last_word  = wlast_reg;

    `ASSERT_PROP(a_out_from_readout, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg) == S_RD_WAIT)
    `ASSERT_NEVER(a_no_write_while_skipping, clk, rst_n, ram_we && skip_reg)
    `ASSERT_PROP(a_adder_idle_when_ready, clk, rst_n,
        in_ready |-> !add_done && !add_start)

endmodule

`default_nettype wire
